[rtl/sitda_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_pkg: shared types and constants
// ascii codes and bcd helpers for the signed integer to decimal text block
// ----------------------------------------------------------------------------
package sitda_pkg;

   // one ascii character and one bcd digit
   typedef logic [7:0] char_type;
   typedef logic [3:0] digit_type;

   // ascii codes
   localparam char_type ASCII_ZERO  = 8'd48;
   localparam char_type ASCII_MINUS = 8'd45;

   // largest decimal digit value
   localparam digit_type DIGIT_MAX = 4'd9;

   // double dabble correction: digits at or above this get plus three
   localparam digit_type DABBLE_LIMIT = 4'd5;
   localparam digit_type DABBLE_ADD   = 4'd3;

   // binary bits consumed by one pipeline stage
   localparam int STEP_BITS = 4;

endpackage
`default_nettype wire

[rtl/signed_int_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer to decimal ascii characters
// path: input stage, double dabble stages, digit count stage, serializer, output register
// throughput: one character per cycle while rsp_ready is not held low; a word holds
//   the serializer until its last character goes out (sign plus up to ten digits at 32 bits)
// reset: synchronous, clears all valid bits; data registers are not reset
// ----------------------------------------------------------------------------
`default_nettype none
module signed_int_to_decimal_ascii #(
   parameter int VALUE_BITS = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire signed [VALUE_BITS-1:0]  req_value,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [7:0]                   rsp_character,
   output logic                         rsp_last
);

   // sizes derived from the value width
   localparam int DIGITS  = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int NS      = (VALUE_BITS + sitda_pkg::STEP_BITS - 1) / sitda_pkg::STEP_BITS;
   localparam int PAD     = NS * sitda_pkg::STEP_BITS;
   localparam int BCD_W   = DIGITS * 4;
   localparam int SHIFT_W = BCD_W + PAD;
   localparam int PTR_W   = $clog2(DIGITS);

   // one group of double dabble steps: correct each digit, then shift left
   function automatic logic [SHIFT_W-1:0] dabble(input logic [SHIFT_W-1:0] word);
      logic [SHIFT_W-1:0] w;
      w = word;
      for (int s = 0; s < sitda_pkg::STEP_BITS; s++) begin
         for (int d = 0; d < DIGITS; d++) begin
            if (w[PAD+4*d +: 4] >= sitda_pkg::DABBLE_LIMIT) begin
               w[PAD+4*d +: 4] = w[PAD+4*d +: 4] + sitda_pkg::DABBLE_ADD;
            end
         end
         w = {w[SHIFT_W-2:0], 1'b0};
      end
      return w;
   endfunction

   // conversion pipeline: stage 0 holds the magnitude, stage k after k groups of steps
   logic [NS:0]        valid_ff;
   logic [SHIFT_W-1:0] shift_ff [0:NS];
   logic               neg_ff   [0:NS];
   logic [SHIFT_W-1:0] shift_in [0:NS];
   logic [NS:0]        adv;

   // digit count stage
   logic                                  cnt_valid_ff;
   logic [DIGITS-1:0][3:0]                cnt_bcd_ff;
   logic [PTR_W-1:0]                      cnt_top_ff;
   logic                                  cnt_neg_ff;
   logic [DIGITS-1:0][3:0]                fin_bcd;
   logic [PTR_W-1:0]                      cnt_top_in;
   logic                                  cnt_ready;

   // serializer and output register
   logic                   ser_busy_ff;
   logic [DIGITS-1:0][3:0] ser_bcd_ff;
   logic [PTR_W-1:0]       ser_ptr_ff;
   logic                   ser_minus_ff;
   logic                   ser_last;
   logic                   ser_ready;
   sitda_pkg::char_type    ser_char;
   logic                   rsp_valid_ff;
   sitda_pkg::char_type    rsp_char_ff;
   logic                   rsp_last_ff;
   logic                   out_free;

   // magnitude, one bit wider in meaning so the most negative value works
   logic [VALUE_BITS-1:0]  raw;
   logic                   raw_neg;
   logic [VALUE_BITS-1:0]  mag_in;

   assign raw     = req_value;
   assign raw_neg = raw[VALUE_BITS-1];
   assign mag_in  = raw_neg ? (~raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;

   // next contents of each conversion stage
   always_comb begin
      shift_in[0] = SHIFT_W'(mag_in);
      for (int k = 1; k <= NS; k++) begin
         shift_in[k] = dabble(shift_ff[k-1]);
      end
   end

   // stall chain: a stage takes a word when empty or when it moves on
   always_comb begin
      adv[NS] = !valid_ff[NS] || cnt_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign req_ready = adv[0];

   // index of the highest nonzero digit, zero for the value zero
   always_comb begin
      fin_bcd    = shift_ff[NS][SHIFT_W-1 -: BCD_W];
      cnt_top_in = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (fin_bcd[i] != 4'd0) begin
            cnt_top_in = PTR_W'(i);
         end
      end
   end

   // serializer handshake and current character
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign ser_last  = !ser_minus_ff && (ser_ptr_ff == '0);
   assign ser_ready = !ser_busy_ff || (out_free && ser_last);
   assign cnt_ready = !cnt_valid_ff || ser_ready;
   assign ser_char  = ser_minus_ff ? sitda_pkg::ASCII_MINUS :
                      sitda_pkg::ASCII_ZERO + {4'b0000, ser_bcd_ff[ser_ptr_ff]};

   // pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         cnt_valid_ff <= 1'b0;
         ser_busy_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // input stage
         if (adv[0]) begin
            valid_ff[0] <= req_valid;
            shift_ff[0] <= shift_in[0];
            neg_ff[0]   <= raw_neg;
         end
         // double dabble stages
         for (int k = 1; k <= NS; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
               shift_ff[k] <= shift_in[k];
               neg_ff[k]   <= neg_ff[k-1];
            end
         end
         // digit count stage
         if (cnt_ready) begin
            cnt_valid_ff <= valid_ff[NS];
            cnt_bcd_ff   <= fin_bcd;
            cnt_top_ff   <= cnt_top_in;
            cnt_neg_ff   <= neg_ff[NS];
         end
         // emit one character into the output register
         if (out_free) begin
            rsp_valid_ff <= ser_busy_ff;
            if (ser_busy_ff) begin
               rsp_char_ff <= ser_char;
               rsp_last_ff <= ser_last;
               if (ser_minus_ff) begin
                  ser_minus_ff <= 1'b0;
               end else if (!ser_last) begin
                  ser_ptr_ff <= ser_ptr_ff - 1'b1;
               end
            end
         end
         // load the next word once the current one has gone out
         if (ser_ready) begin
            ser_busy_ff <= cnt_valid_ff;
            if (cnt_valid_ff) begin
               ser_bcd_ff   <= cnt_bcd_ff;
               ser_ptr_ff   <= cnt_top_ff;
               ser_minus_ff <= cnt_neg_ff;
            end
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   // a word offered to the serializer is taken and keeps it busy
   assert property (@(posedge clock) disable iff (reset)
      (ser_ready && cnt_valid_ff) |=> ser_busy_ff)
      else $error("serializer dropped a word");

   // a blocked last conversion stage keeps its word
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[NS] && !cnt_ready) |=> valid_ff[NS])
      else $error("conversion stage lost a word under stall");

   // digit pointer stays inside the digit array
   assert property (@(posedge clock) disable iff (reset)
      ser_busy_ff |-> (ser_ptr_ff <= PTR_W'(DIGITS - 1)))
      else $error("digit pointer out of range");

   // only a minus sign or a decimal digit ever leaves
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_char_ff == sitda_pkg::ASCII_MINUS ||
         (rsp_char_ff >= sitda_pkg::ASCII_ZERO &&
          rsp_char_ff <= sitda_pkg::ASCII_ZERO + {4'b0000, sitda_pkg::DIGIT_MAX})))
      else $error("bad character code");

   // a minus sign is never the final character
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_char_ff == sitda_pkg::ASCII_MINUS) |-> !rsp_last_ff)
      else $error("minus sign flagged as last");

endmodule
`default_nettype wire
